/* hdl/bfa_pkg.sv */
// Package with the types, codes and sizes shared by the block fit allocator.
package bfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SIZE_W     = 16;
    localparam int BLKID_W    = 4;
    localparam int MODE_W     = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [BLKID_W-1:0] block_index;
        logic [SIZE_W-1:0]  size_value;
    } in_item_t;

    typedef struct packed {
        logic               granted;
        logic [BLKID_W-1:0] chosen_block;
        logic [SIZE_W-1:0]  room_left;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_alloc;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/bfa_datapath.sv */
// Datapath of the block fit allocator: free size table, scan compare and output register.
module bfa_datapath
    import bfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_data,
    output out_item_t   out_data,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    logic [SIZE_W-1:0] free_size_reg [NUM_BLOCKS];
    logic [MODE_W-1:0] mode_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SIZE_W-1:0] best_left_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [SIZE_W-1:0] have;
    logic [SIZE_W-1:0] left;
    logic              fits;
    logic              take;
    logic              load_hit;

    assign have     = free_size_reg[cnt_reg];
    assign fits     = (have >= req_reg);
    assign left     = have - req_reg;
    assign load_hit = (in_data.cmd == CMD_LOAD) && (32'(in_data.block_index) < NUM_BLOCKS);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            unique case (mode_reg)
                MODE_BEST:  take = !found_reg || (left < best_left_reg);
                MODE_WORST: take = !found_reg || (left > best_left_reg);
                default:    take = !found_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                free_size_reg[i] <= '0;
            end
            mode_reg      <= MODE_FIRST;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (take)
                begin
                    found_reg     <= 1'b1;
                    best_idx_reg  <= cnt_reg;
                    best_left_reg <= left;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (found_reg)
                begin
                    free_size_reg[best_idx_reg] <= best_left_reg;
                    out_data_reg.granted        <= 1'b1;
                    out_data_reg.chosen_block   <= BLKID_W'(best_idx_reg);
                    out_data_reg.room_left      <= best_left_reg;
                end
                else
                begin
                    out_data_reg <= '0;
                end
            end
            // A load that follows a commit in the same cycle is the later transfer.
            if (cmd.accept)
            begin
                req_reg   <= in_data.size_value;
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                if (load_hit)
                begin
                    free_size_reg[in_data.block_index[IDX_W-1:0]] <= in_data.size_value;
                end
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data           = out_data_reg;
    assign status.in_is_alloc = (in_data.cmd == CMD_ALLOC);
    assign status.scan_last   = (cnt_reg == IDX_W'(NUM_BLOCKS - 1));
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

/* hdl/bfa_ctrl.sv */
// Controller state machine of the block fit allocator.
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.in_is_alloc)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    in_ready   = 1'b1;
                    state_next = ST_IDLE;
                    if (in_valid)
                    begin
                        cmd.accept = 1'b1;
                        if (status.in_is_alloc)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/block_fit_allocator.sv */
// Top level of the block fit allocator.
// The block keeps a table of free sizes for NUM_BLOCKS memory blocks.
// Input transfers on in_valid/in_ready carry a command, a block index and a size.
// A load command writes a block's free size and produces no result.
// An allocate command scans the table one entry per cycle and picks a block
// according to the fit mode written on cfg_we/cfg_data (first, best or worst fit).
// Each allocate produces one result transfer on out_valid/out_ready that reports
// whether it was granted, the chosen block and the room left in it.
// The scan walks the single table read port, so no new item is taken while an
// allocate is scanning; the next one can be taken as soon as its result is committed.
// The result sits in an output register; a new item is taken while it waits,
// but the next allocate holds at the end of its scan until that register is free.
// Reset clears the table to zero, the fit mode to first fit and all valid flags.
module block_fit_allocator
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bfa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* tb/sv/tb.sv */
// Testbench for the block fit allocator: a directed table, then random transfers checked against a table model.
module tb;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam out_item_t REFUSED = '0;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        in_item_t          item;
        logic              typed;
        out_item_t         result;
    } dir_row_t;

    typedef struct packed {
        logic      typed;
        out_item_t result;
    } grant_note_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [1:0] cfg_data = '0;

    logic [SIZE_W-1:0] free_tab [NUM_BLOCKS];
    logic [MODE_W-1:0] mode_now;
    out_item_t         expected_grants [$];
    grant_note_t       grant_notes [$];
    int                mismatch_count = 0;
    bit                no_idle = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;

    dir_row_t script [23] = '{
        '{MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'd0}, 1'b1, '{1'b1, 4'd0, 16'd0}},
        '{MODE_FIRST, '{CMD_ALLOC, 4'd9, 16'd1}, 1'b1, REFUSED},
        '{MODE_FIRST, '{CMD_ALLOC, 4'd15, 16'd65535}, 1'b1, REFUSED},
        '{MODE_FIRST, '{CMD_LOAD, 4'd15, 16'd65535}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'd65535}, 1'b1, '{1'b1, 4'd15, 16'd0}},
        '{MODE_FIRST, '{CMD_LOAD, 4'd3, 16'd500}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_LOAD, 4'd7, 16'd300}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_LOAD, 4'd12, 16'd300}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_LOAD, 4'd1, 16'd100}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'd200}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'd0}, 1'b0, REFUSED},
        '{MODE_BEST, '{CMD_ALLOC, 4'd0, 16'd250}, 1'b0, REFUSED},
        '{MODE_BEST, '{CMD_ALLOC, 4'd0, 16'd100}, 1'b0, REFUSED},
        '{MODE_BEST, '{CMD_ALLOC, 4'd0, 16'd0}, 1'b0, REFUSED},
        '{MODE_WORST, '{CMD_LOAD, 4'd10, 16'd65535}, 1'b0, REFUSED},
        '{MODE_WORST, '{CMD_ALLOC, 4'd0, 16'd1}, 1'b0, REFUSED},
        '{MODE_WORST, '{CMD_ALLOC, 4'd0, 16'd65535}, 1'b1, REFUSED},
        '{MODE_WORST, '{CMD_ALLOC, 4'd0, 16'd0}, 1'b0, REFUSED},
        '{MODE_SPARE, '{CMD_ALLOC, 4'd0, 16'd50}, 1'b0, REFUSED},
        '{MODE_SPARE, '{CMD_LOAD, 4'd0, 16'd65535}, 1'b0, REFUSED},
        '{MODE_SPARE, '{CMD_ALLOC, 4'd15, 16'd65535}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_LOAD, 4'd10, 16'd0}, 1'b0, REFUSED},
        '{MODE_FIRST, '{CMD_ALLOC, 4'd0, 16'd65534}, 1'b1, REFUSED}
    };

    logic [MODE_W-1:0] phase_modes [8] = '{MODE_BEST, MODE_WORST, MODE_FIRST, MODE_SPARE,
                                           MODE_WORST, MODE_BEST, MODE_FIRST, MODE_BEST};

    block_fit_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic out_item_t fit_request(input logic [SIZE_W-1:0] req);
        out_item_t         res;
        int                pick;
        logic [SIZE_W-1:0] pick_left;
        logic [SIZE_W-1:0] left;
        res = '0;
        pick = -1;
        pick_left = '0;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            if (free_tab[i] >= req)
            begin
                left = free_tab[i] - req;
                if (mode_now == MODE_BEST)
                begin
                    if (pick < 0 || left < pick_left)
                    begin
                        pick = i;
                        pick_left = left;
                    end
                end
                else if (mode_now == MODE_WORST)
                begin
                    if (pick < 0 || left > pick_left)
                    begin
                        pick = i;
                        pick_left = left;
                    end
                end
                else if (pick < 0)
                begin
                    pick = i;
                    pick_left = left;
                end
            end
        end
        if (pick >= 0)
        begin
            free_tab[pick] = pick_left;
            res.granted = 1'b1;
            res.chosen_block = pick[BLKID_W-1:0];
            res.room_left = pick_left;
        end
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t make_item();
        in_item_t          it;
        int                r;
        int                k;
        logic [SIZE_W-1:0] base;
        it.block_index = BLKID_W'($urandom_range(0, NUM_BLOCKS - 1));
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 40)
        begin
            it.cmd = CMD_LOAD;
            if (r < 35)
                it.size_value = SIZE_W'($urandom_range(0, 1023));
            else if (r < 55)
                it.size_value = 16'(16 << (2 * $urandom_range(0, 3)));
            else if (r < 75)
                it.size_value = SIZE_W'($urandom_range(0, 65535));
            else if (r < 88)
                it.size_value = '0;
            else
                it.size_value = '1;
        end
        else
        begin
            it.cmd = CMD_ALLOC;
            base = free_tab[BLKID_W'($urandom_range(0, NUM_BLOCKS - 1))];
            k = $urandom_range(1, 8);
            if (r < 30)
                it.size_value = base;
            else if (r < 50)
                it.size_value = (base > k) ? 16'(base - k) : '0;
            else if (r < 65)
                it.size_value = SIZE_W'($urandom_range(0, 255));
            else if (r < 75)
                it.size_value = '0;
            else if (r < 88)
                it.size_value = SIZE_W'($urandom_range(0, 65535));
            else
                it.size_value = '1;
        end
        return it;
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : monitor
        grant_note_t note;
        out_item_t   predicted;
        out_item_t   want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                note = grant_notes.pop_front();
                if (in_data.cmd == CMD_ALLOC)
                begin
                    predicted = fit_request(in_data.size_value);
                    expected_grants.push_back(note.typed ? note.result : predicted);
                end
                else if (in_data.block_index < NUM_BLOCKS)
                    free_tab[in_data.block_index] = in_data.size_value;
            end
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: result transfer with none expected, actual %0d/%0d/%0d",
                             $time, out_data.granted, out_data.chosen_block,
                             out_data.room_left);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (out_data.granted !== want.granted)
                        report("granted", int'(want.granted), int'(out_data.granted));
                    if (out_data.chosen_block !== want.chosen_block)
                        report("chosen_block", int'(want.chosen_block),
                               int'(out_data.chosen_block));
                    if (out_data.room_left !== want.room_left)
                        report("room_left", int'(want.room_left), int'(out_data.room_left));
                end
            end
        end
    end

    task automatic send_item(input in_item_t item, input logic typed, input out_item_t result);
        int gap;
        grant_notes.push_back(grant_note_t'{typed, result});
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (NUM_BLOCKS + 4) @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_now = m;
    endtask

    initial
    begin : stimulus
        foreach (free_tab[i])
            free_tab[i] = '0;
        mode_now = MODE_FIRST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[k])
        begin
            if (script[k].mode != mode_now)
                set_mode(script[k].mode);
            send_item(script[k].item, script[k].typed, script[k].result);
        end
        phase_modes[7] = MODE_W'($urandom_range(0, 3));
        for (int p = 0; p < 8; p++)
        begin
            set_mode(phase_modes[p]);
            for (int n = 0; n < 166; n++)
            begin
                if (n % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (p == 1 && n == 20)
                    hold_req = 1'b1;
                send_item(make_item(), 1'b0, '0);
            end
        end
        no_idle = 1'b0;
        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : receiver
        int run;
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (400) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
